### rtl/core/assert_macros.svh
// Assertion helpers for the fault monitor.
// Every property is sampled on the rising clock edge and is off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every clock edge.
`define AFM_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never occurs at any clock edge.
`define AFM_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`else

`define AFM_ASSERT(name, prop, msg)

`define AFM_ASSERT_NEVER(name, cond, msg)

`endif

`endif

### rtl/core/afm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afm_pkg;

   // Default sizes handed to the top level parameters.
   localparam int FEEDBACK_BITS_DEFAULT = 8;
   localparam int TIME_BITS_DEFAULT     = 48;
   localparam int QUEUE_DEPTH_DEFAULT   = 4;

   // Fixed field widths.
   localparam int GEN_BITS       = 32;
   localparam int COUNT_BITS     = 16;
   localparam int FLAG_BITS      = 5;
   localparam int MASK_BITS      = 8;
   localparam int AGE_BITS       = 32;
   localparam int FAULT_COUNT    = 6;
   localparam int EVENT_BITS     = FAULT_COUNT + 1;
   localparam int OUT_TIME_BITS  = 48;
   localparam int EMIT_BITS      = 3;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;

   // Positions in condition_flags.
   localparam int FLAG_CONFIG_OK   = 0;
   localparam int FLAG_BUS_OFF     = 1;
   localparam int FLAG_DRIVE_CRIT  = 2;
   localparam int FLAG_LOCAL_LIMIT = 3;
   localparam int FLAG_RECOVERED   = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_TIMEOUTS = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REQUIRED_FB  = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_AGE      = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KNOWN_FB     = 4'd3;

   localparam logic [MASK_BITS-1:0] KNOWN_MASK_RESET = 8'hFF;

   // Result kinds.
   localparam logic KIND_EVENT  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Event reasons; the fault reasons equal their bit position.
   localparam logic [2:0] REASON_CONFIG      = 3'd0;
   localparam logic [2:0] REASON_BUS_OFF     = 3'd1;
   localparam logic [2:0] REASON_TIMEOUT     = 3'd2;
   localparam logic [2:0] REASON_DRIVE_CRIT  = 3'd3;
   localparam logic [2:0] REASON_LOCAL_LIMIT = 3'd4;
   localparam logic [2:0] REASON_FEEDBACK    = 3'd5;
   localparam logic [2:0] REASON_INTEGRITY   = 3'd6;

   typedef enum logic [2:0] {
      ST_OK               = 3'd0,
      ST_LATCHED          = 3'd1,
      ST_ACTIVE           = 3'd2,
      ST_RECOVERY         = 3'd3,
      ST_INVALID_POLICY   = 3'd4,
      ST_CLOCK_REGRESSION = 3'd5,
      ST_INVALID_SAMPLE   = 3'd6
   } status_type;

   // One classified sample as it waits between the front and the back.
   typedef struct packed {
      logic [EVENT_BITS-1:0]    ev_mask;
      status_type               status;
      logic [FAULT_COUNT-1:0]   active;
      logic [FAULT_COUNT-1:0]   fresh;
      logic [OUT_TIME_BITS-1:0] evt_time;
      logic [OUT_TIME_BITS-1:0] now;
   } desc_type;

endpackage

`default_nettype wire

### rtl/core/afm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Sample channel.
interface afm_req_if import afm_pkg::*; #(
   parameter int FEEDBACK_BITS = FEEDBACK_BITS_DEFAULT,
   parameter int TIME_BITS     = TIME_BITS_DEFAULT
) ();
   logic                     valid;
   logic                     ready;
   logic [TIME_BITS-1:0]     now_ms;
   logic [FEEDBACK_BITS-1:0] feedback_valid_bits;
   logic [GEN_BITS-1:0]      feedback_generation;
   logic [TIME_BITS-1:0]     feedback_sampled_ms;
   logic [TIME_BITS-1:0]     feedback_received_ms;
   logic [COUNT_BITS-1:0]    timeout_run;
   logic [COUNT_BITS-1:0]    timeout_total;
   logic [FLAG_BITS-1:0]     condition_flags;
   logic                     measurements_nonzero;

   modport source (
      output valid, now_ms, feedback_valid_bits, feedback_generation,
             feedback_sampled_ms, feedback_received_ms, timeout_run,
             timeout_total, condition_flags, measurements_nonzero,
      input  ready
   );
   modport sink (
      input  valid, now_ms, feedback_valid_bits, feedback_generation,
             feedback_sampled_ms, feedback_received_ms, timeout_run,
             timeout_total, condition_flags, measurements_nonzero,
      output ready
   );
endinterface

// Result channel.
interface afm_rsp_if import afm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     item_kind;
   logic [2:0]               status_code;
   logic [FAULT_COUNT-1:0]   active_faults;
   logic [FAULT_COUNT-1:0]   new_faults;
   logic [2:0]               event_reason;
   logic [OUT_TIME_BITS-1:0] event_time_ms;
   logic [EMIT_BITS-1:0]     events_emitted;
   logic                     last_item;

   modport source (
      output valid, item_kind, status_code, active_faults, new_faults,
             event_reason, event_time_ms, events_emitted, last_item,
      input  ready
   );
   modport sink (
      input  valid, item_kind, status_code, active_faults, new_faults,
             event_reason, event_time_ms, events_emitted, last_item,
      output ready
   );
endinterface

// Configuration write channel.
interface afm_csr_if import afm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/actuator_fault_monitor.sv
// In an idle block the first result of a sample passes through the queue and then the output register.
// A sample yields one result per fault bit that became active, or one integrity event,
// plus its report, so 1 to 7 results; the result port gives one result per cycle while
// rsp_ch.ready holds, and the queue (four entries by default) keeps taking samples meanwhile.
// Reset clears the queue, the output valid flag, the clock and fault state and the
// configuration registers to their reset values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module actuator_fault_monitor import afm_pkg::*; #(
   parameter int FEEDBACK_BITS = FEEDBACK_BITS_DEFAULT,
   parameter int TIME_BITS     = TIME_BITS_DEFAULT,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   afm_req_if.sink    req_ch,
   afm_rsp_if.source  rsp_ch,
   afm_csr_if.sink    csr_ch
);

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   desc_type q_data;
   desc_type q_head;

   // Front end: checks and classifies each sample.
   afm_front #(
      .FEEDBACK_BITS (FEEDBACK_BITS),
      .TIME_BITS     (TIME_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_data)
   );

   // Queue of classified samples.
   afm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // Back end: emits events and the report.
   afm_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (q_head),
      .empty  (q_empty),
      .pop    (q_pop),
      .rsp_ch (rsp_ch)
   );

   `AFM_ASSERT_NEVER(a_pop_empty, q_pop && q_empty, "queue popped while empty")
   `AFM_ASSERT(a_fresh_subset, rsp_ch.valid |-> ((rsp_ch.new_faults & ~rsp_ch.active_faults) == '0), "new faults not within active faults")
   `AFM_ASSERT(a_integrity_status, (rsp_ch.valid && rsp_ch.item_kind == KIND_EVENT && rsp_ch.event_reason == REASON_INTEGRITY) |-> (rsp_ch.status_code == ST_RECOVERY || rsp_ch.status_code == ST_INVALID_POLICY || rsp_ch.status_code == ST_CLOCK_REGRESSION || rsp_ch.status_code == ST_INVALID_SAMPLE), "integrity event with fault status")

endmodule

`default_nettype wire

### rtl/core/afm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module afm_front import afm_pkg::*; #(
   parameter int FEEDBACK_BITS = FEEDBACK_BITS_DEFAULT,
   parameter int TIME_BITS     = TIME_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   afm_req_if.sink    req_ch,
   afm_csr_if.sink    csr_ch,
   input  wire logic  q_full,
   output logic       q_push,
   output desc_type   q_data
);

   logic [COUNT_BITS-1:0] max_timeouts_ff;
   logic [MASK_BITS-1:0]  required_mask_ff;
   logic [AGE_BITS-1:0]   max_age_ff;
   logic [MASK_BITS-1:0]  known_mask_ff;

   logic                   started_ff;
   logic [TIME_BITS-1:0]   last_time_ff;
   logic [FAULT_COUNT-1:0] active_ff;

   logic [FEEDBACK_BITS-1:0] known;
   logic [FEEDBACK_BITS-1:0] required;
   logic [FEEDBACK_BITS-1:0] vbits;
   logic [TIME_BITS-1:0]     now;
   logic [TIME_BITS-1:0]     sampled;
   logic [TIME_BITS-1:0]     received;
   logic [TIME_BITS-1:0]     age;
   logic [FLAG_BITS-1:0]     flags;
   logic                     policy_bad;
   logic                     recovery_bad;
   logic                     clock_bad;
   logic                     sample_ok;
   logic                     clock_ok;
   logic [FAULT_COUNT-1:0]   cur;
   logic [FAULT_COUNT-1:0]   fresh;

   // Configuration writes are always taken; unknown indexes are dropped.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_timeouts_ff  <= '0;
         required_mask_ff <= '0;
         max_age_ff       <= '0;
         known_mask_ff    <= KNOWN_MASK_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_MAX_TIMEOUTS: max_timeouts_ff  <= csr_ch.data[COUNT_BITS-1:0];
            CSR_REQUIRED_FB:  required_mask_ff <= csr_ch.data[MASK_BITS-1:0];
            CSR_MAX_AGE:      max_age_ff       <= csr_ch.data[AGE_BITS-1:0];
            CSR_KNOWN_FB:     known_mask_ff    <= csr_ch.data[MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign known    = FEEDBACK_BITS'(known_mask_ff);
   assign required = FEEDBACK_BITS'(required_mask_ff);
   assign vbits    = req_ch.feedback_valid_bits;
   assign now      = req_ch.now_ms;
   assign sampled  = req_ch.feedback_sampled_ms;
   assign received = req_ch.feedback_received_ms;
   assign flags    = req_ch.condition_flags;
   assign age      = now - received;

   // Integrity checks, in priority order.
   assign policy_bad = (max_timeouts_ff == '0) || (required == '0) ||
                       ((required & ~known) != '0) || (max_age_ff == '0);
   assign recovery_bad = !flags[FLAG_RECOVERED];
   assign clock_bad    = started_ff && (now < last_time_ff);
   assign clock_ok     = !policy_bad && !recovery_bad && !clock_bad;

   // Structural check of the sample.
   always_comb begin
      if (((vbits & ~known) != '0) || (req_ch.timeout_run > req_ch.timeout_total)) begin
         sample_ok = 1'b0;
      end else if (vbits == '0) begin
         sample_ok = (req_ch.feedback_generation == '0) && (sampled == '0) &&
                     (received == '0) && !req_ch.measurements_nonzero;
      end else begin
         sample_ok = (req_ch.feedback_generation != '0) && (received >= sampled) &&
                     (received <= now);
      end
   end

   // Fault conditions of this sample.
   always_comb begin
      cur    = '0;
      cur[0] = !flags[FLAG_CONFIG_OK];
      cur[1] = flags[FLAG_BUS_OFF];
      cur[2] = req_ch.timeout_run > max_timeouts_ff;
      cur[3] = flags[FLAG_DRIVE_CRIT];
      cur[4] = flags[FLAG_LOCAL_LIMIT];
      cur[5] = ((vbits & required) != required) || (age > TIME_BITS'(max_age_ff));
   end

   assign fresh = cur & ~active_ff;

   // Build the descriptor for the back end.
   always_comb begin
      q_data.ev_mask  = EVENT_BITS'(1) << REASON_INTEGRITY;
      q_data.active   = active_ff;
      q_data.fresh    = '0;
      q_data.evt_time = OUT_TIME_BITS'(now);
      q_data.now      = OUT_TIME_BITS'(now);
      if (policy_bad) begin
         q_data.status = ST_INVALID_POLICY;
      end else if (recovery_bad) begin
         q_data.status = ST_RECOVERY;
      end else if (clock_bad) begin
         q_data.status   = ST_CLOCK_REGRESSION;
         q_data.evt_time = OUT_TIME_BITS'(last_time_ff);
      end else if (!sample_ok) begin
         q_data.status = ST_INVALID_SAMPLE;
      end else begin
         q_data.ev_mask = {1'b0, fresh};
         q_data.active  = cur;
         q_data.fresh   = fresh;
         if (fresh != '0) begin
            q_data.status = ST_LATCHED;
         end else if (cur != '0) begin
            q_data.status = ST_ACTIVE;
         end else begin
            q_data.status = ST_OK;
         end
      end
   end

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   // Monitor state follows each accepted item that passes the policy, recovery and clock checks.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         last_time_ff <= '0;
         active_ff    <= '0;
      end else if (q_push && clock_ok) begin
         started_ff   <= 1'b1;
         last_time_ff <= now;
         if (sample_ok) begin
            active_ff <= cur;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/afm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module afm_queue import afm_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type push_data,
   output logic          full,
   input  wire logic     pop,
   output desc_type      head,
   output logic          empty
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   desc_type            slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [COUNT_W-1:0]  count_in;

   assign full  = (count_ff == COUNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/core/afm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module afm_back import afm_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire desc_type head,
   input  wire logic     empty,
   output logic          pop,
   afm_rsp_if.source     rsp_ch
);

   logic                     started_ff;
   logic [EVENT_BITS-1:0]    rem_ff;
   logic [EMIT_BITS-1:0]     count_ff;
   logic                     valid_ff;
   logic                     kind_ff;
   status_type               status_ff;
   logic [FAULT_COUNT-1:0]   active_ff;
   logic [FAULT_COUNT-1:0]   fresh_ff;
   logic [2:0]               reason_ff;
   logic [OUT_TIME_BITS-1:0] time_ff;
   logic [EMIT_BITS-1:0]     emitted_ff;
   logic                     last_ff;

   logic                  started_in;
   logic [EVENT_BITS-1:0] rem_in;
   logic [EMIT_BITS-1:0]  count_in;
   logic                  valid_in;
   logic                  out_free;
   logic                  step;
   logic [EVENT_BITS-1:0] pend;
   logic [EVENT_BITS-1:0] low_bit;
   logic [2:0]            low_idx;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign step     = !empty && out_free;
   assign pend     = started_ff ? rem_ff : head.ev_mask;
   assign low_bit  = pend & (~pend + 1'b1);
   assign pop      = step && (pend == '0);

   // Index of the lowest pending event, which is also its reason code.
   always_comb begin
      low_idx = REASON_CONFIG;
      for (int i = 0; i < EVENT_BITS; i++) begin
         if (low_bit[i]) begin
            low_idx = 3'(i);
         end
      end
   end

   // Sequencer: one event per pending bit, then the report.
   always_comb begin
      started_in = started_ff;
      rem_in     = rem_ff;
      count_in   = count_ff;
      valid_in   = valid_ff && !rsp_ch.ready;
      if (step) begin
         valid_in = 1'b1;
         if (pend != '0) begin
            started_in = 1'b1;
            rem_in     = pend & ~low_bit;
            count_in   = count_ff + 1'b1;
         end else begin
            started_in = 1'b0;
            rem_in     = '0;
            count_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         rem_ff     <= '0;
         count_ff   <= '0;
         valid_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         rem_ff     <= rem_in;
         count_ff   <= count_in;
         valid_ff   <= valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (step) begin
         status_ff <= head.status;
         active_ff <= head.active;
         fresh_ff  <= head.fresh;
         if (pend != '0) begin
            kind_ff    <= KIND_EVENT;
            reason_ff  <= low_idx;
            time_ff    <= head.evt_time;
            emitted_ff <= '0;
            last_ff    <= 1'b0;
         end else begin
            kind_ff    <= KIND_REPORT;
            reason_ff  <= REASON_CONFIG;
            time_ff    <= head.now;
            emitted_ff <= count_ff;
            last_ff    <= 1'b1;
         end
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.item_kind      = kind_ff;
   assign rsp_ch.status_code    = status_ff;
   assign rsp_ch.active_faults  = active_ff;
   assign rsp_ch.new_faults     = fresh_ff;
   assign rsp_ch.event_reason   = reason_ff;
   assign rsp_ch.event_time_ms  = time_ff;
   assign rsp_ch.events_emitted = emitted_ff;
   assign rsp_ch.last_item      = last_ff;

endmodule

`default_nettype wire
